// File: rtl/srfm_pkg.sv
// ----------------------------------------------------------------------------
// srfm_pkg
// Shared types and constants for the SPI register frame master.
// ----------------------------------------------------------------------------
package srfm_pkg;

  // Width of the data word that follows the address byte (8 to 64).
  localparam int DATA_BITS  = 32;
  localparam int FRAME_BITS = 8 + DATA_BITS;
  localparam int BL_W       = $clog2(FRAME_BITS + 1);
  localparam int DIDX_W     = $clog2(DATA_BITS);

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;

  typedef logic [DATA_BITS-1:0] data_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  addr_byte;
    data_t       data;
    logic        miso;
  } cmd_t;

  // One result as it waits at the output.
  typedef struct packed {
    logic        sck_level;
    logic        mosi_level;
    logic        chip_select_n;
    logic        busy_res;
    logic        frame_done;
    logic [31:0] read_word;
    logic        start_rejected;
  } res_t;

endpackage

// File: rtl/spi_register_frame_master_unit.sv
// ----------------------------------------------------------------------------
// spi_register_frame_master_unit
// SPI mode 0 master running one address byte plus data word frame per start.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port: one is taken at each rising edge
// with push high and full low. A request is either a start (mode 0), which
// loads the address byte, with bit 7 set for reads, and the data word, or a
// tick (mode 1), which advances time by one step and carries the MISO level.
// Every request produces exactly one result, in order, holding the pin levels
// after that request plus the done, received word and rejection flags.
// Results wait on the output ports while empty is low and leave on pop.
// The half-period register is written over its own valid/ready channel; ready
// is always high, and a new value is used from the next tick on.
// A request is held in the request queue, then the engine handles it and
// writes its result into the result queue, from which it can be popped; one
// request per cycle is sustained while the consumer keeps popping: the engine
// handles any request combinationally, as the counter increment and
// compare plus the MOSI bit select are the deepest paths.
// When the consumer stops popping, the two-entry result queue fills, the
// engine stalls, then the two-entry request queue fills and full rises; no
// request or result is dropped. Reset returns both queues to empty, sets the
// half period to 100, SCK low, MOSI low and chip select high.
// ----------------------------------------------------------------------------
module spi_register_frame_master_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [6:0]  reg_address,
  input  logic [31:0] write_data,
  input  logic        read_request,
  input  logic        miso_level,
  input  logic        pop,
  output logic        empty,
  output logic        sck_level,
  output logic        mosi_level,
  output logic        chip_select_n,
  output logic        busy_res,
  output logic        frame_done,
  output logic [31:0] read_word,
  output logic        start_rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] half_period_ticks
);

  logic           cmd_valid;
  logic           cmd_take;
  srfm_pkg::cmd_t cmd;
  srfm_pkg::res_t res;

  // The register write is always taken in the cycle it is offered.
  assign cfg_ready = 1'b1;

  // Front: takes requests, decodes start or tick and queues them.
  srfm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .mode         (mode),
    .reg_address  (reg_address),
    .write_data   (write_data),
    .read_request (read_request),
    .miso_level   (miso_level),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  // Back: frame engine and result queue.
  srfm_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid && cfg_ready),
    .half_period_ticks (half_period_ticks),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_take          (cmd_take),
    .res_pop           (pop),
    .res_empty         (empty),
    .res               (res)
  );

  // Result fields straight from the head of the result queue.
  assign sck_level      = res.sck_level;
  assign mosi_level     = res.mosi_level;
  assign chip_select_n  = res.chip_select_n;
  assign busy_res       = res.busy_res;
  assign frame_done     = res.frame_done;
  assign read_word      = res.read_word;
  assign start_rejected = res.start_rejected;

endmodule

// File: rtl/srfm_front.sv
// ----------------------------------------------------------------------------
// srfm_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module srfm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               mode,
  input  logic [6:0]         reg_address,
  input  logic [31:0]        write_data,
  input  logic               read_request,
  input  logic               miso_level,
  output logic               cmd_valid,
  output srfm_pkg::cmd_t     cmd,
  input  logic               cmd_take
);

  srfm_pkg::cmd_t cmd_mem [2];
  srfm_pkg::cmd_t cmd_in;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  // The address byte is built here so that the back only shifts it out.
  always_comb begin
    cmd_in.addr_byte = {read_request, reg_address};
    cmd_in.data      = srfm_pkg::data_t'(write_data);
    cmd_in.miso      = miso_level;
    unique case (mode)
      1'b0:    cmd_in.kind = srfm_pkg::CMD_START;
      default: cmd_in.kind = srfm_pkg::CMD_TICK;
    endcase
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = cmd_mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

// File: rtl/srfm_back.sv
// ----------------------------------------------------------------------------
// srfm_back
// Frame engine: runs the SCK timing and shift registers, queues results.
// ----------------------------------------------------------------------------
module srfm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [15:0]        half_period_ticks,
  input  logic               cmd_valid,
  input  srfm_pkg::cmd_t     cmd,
  output logic               cmd_take,
  input  logic               res_pop,
  output logic               res_empty,
  output srfm_pkg::res_t     res
);

  logic [15:0]                 half_period;
  logic [7:0]                  tx_addr;
  srfm_pkg::data_t             tx_data;
  srfm_pkg::data_t             rx_data;
  logic [srfm_pkg::BL_W-1:0]   bits_left;
  logic [15:0]                 delay_count;
  logic                        clock_high;
  logic                        frame_active;

  logic [7:0]                  tx_addr_next;
  srfm_pkg::data_t             tx_data_next;
  srfm_pkg::data_t             rx_data_next;
  logic [srfm_pkg::BL_W-1:0]   bits_left_next;
  logic [15:0]                 delay_count_next;
  logic                        clock_high_next;
  logic                        frame_active_next;

  logic [15:0]                 hp;
  logic [16:0]                 count_inc;
  logic [srfm_pkg::BL_W-1:0]   bit_idx;
  logic [srfm_pkg::BL_W-1:0]   addr_idx;
  logic [63:0]                 rx_wide;
  logic                        mosi;
  logic                        done;
  logic                        rejected;
  srfm_pkg::res_t              res_in;

  srfm_pkg::res_t              res_mem [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  res_count;
  logic                        do_pop;

  assign cmd_take = cmd_valid && (res_count != 2'd2);
  assign do_pop   = res_pop && !res_empty;

  always_comb begin
    hp        = (half_period == 16'd0) ? 16'd1 : half_period;
    count_inc = {1'b0, delay_count} + 17'd1;
    tx_addr_next      = tx_addr;
    tx_data_next      = tx_data;
    rx_data_next      = rx_data;
    bits_left_next    = bits_left;
    delay_count_next  = delay_count;
    clock_high_next   = clock_high;
    frame_active_next = frame_active;
    done              = 1'b0;
    rejected          = 1'b0;
    unique case (cmd.kind)
      srfm_pkg::CMD_START: begin
        if (frame_active) begin
          rejected = 1'b1;
        end else begin
          tx_addr_next      = cmd.addr_byte;
          tx_data_next      = cmd.data;
          rx_data_next      = '0;
          bits_left_next    = srfm_pkg::BL_W'(srfm_pkg::FRAME_BITS);
          delay_count_next  = 16'd0;
          clock_high_next   = 1'b0;
          frame_active_next = 1'b1;
        end
      end
      default: begin
        if (frame_active) begin
          if (count_inc >= {1'b0, hp}) begin
            delay_count_next = 16'd0;
            if (!clock_high) begin
              clock_high_next = 1'b1;
              if (bits_left <= srfm_pkg::BL_W'(srfm_pkg::DATA_BITS)) begin
                rx_data_next = {rx_data[srfm_pkg::DATA_BITS-2:0], cmd.miso};
              end
            end else begin
              clock_high_next = 1'b0;
              if (bits_left != '0) begin
                bits_left_next = bits_left - srfm_pkg::BL_W'(1);
              end
              if (bits_left_next == '0) begin
                frame_active_next = 1'b0;
                done              = 1'b1;
              end
            end
          end else begin
            delay_count_next = count_inc[15:0];
          end
        end
      end
    endcase
  end

  // MOSI follows the bit now in progress, taken from the state after the request.
  always_comb begin
    bit_idx  = bits_left_next - srfm_pkg::BL_W'(1);
    addr_idx = bit_idx - srfm_pkg::BL_W'(srfm_pkg::DATA_BITS);
    if (!frame_active_next || bits_left_next == '0) begin
      mosi = 1'b0;
    end else if (bit_idx >= srfm_pkg::BL_W'(srfm_pkg::DATA_BITS)) begin
      mosi = tx_addr_next[addr_idx[2:0]];
    end else begin
      mosi = tx_data_next[bit_idx[srfm_pkg::DIDX_W-1:0]];
    end
  end

  always_comb begin
    rx_wide               = 64'(rx_data);
    res_in.sck_level      = clock_high_next;
    res_in.mosi_level     = mosi;
    res_in.chip_select_n  = !frame_active_next;
    res_in.busy_res       = frame_active_next;
    res_in.frame_done     = done;
    res_in.read_word      = done ? rx_wide[31:0] : 32'd0;
    res_in.start_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period  <= srfm_pkg::HALF_PERIOD_RESET;
      tx_addr      <= '0;
      tx_data      <= '0;
      rx_data      <= '0;
      bits_left    <= '0;
      delay_count  <= '0;
      clock_high   <= 1'b0;
      frame_active <= 1'b0;
    end else begin
      if (cfg_valid) begin
        half_period <= half_period_ticks;
      end
      if (cmd_take) begin
        tx_addr      <= tx_addr_next;
        tx_data      <= tx_data_next;
        rx_data      <= rx_data_next;
        bits_left    <= bits_left_next;
        delay_count  <= delay_count_next;
        clock_high   <= clock_high_next;
        frame_active <= frame_active_next;
      end
    end
  end

  // Two-entry result queue: the engine keeps going while one result waits.
  assign res_empty = (res_count == 2'd0);
  assign res       = res_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      res_count <= 2'd0;
    end else begin
      if (cmd_take) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      res_count <= res_count + {1'b0, cmd_take} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      res_mem[wr_ptr] <= res_in;
    end
  end

endmodule

// File: rtl/srfm_checker.sv
// ----------------------------------------------------------------------------
// srfm_checker
// Port-level checks on the results of the SPI register frame master.
// ----------------------------------------------------------------------------
module srfm_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        sck_level,
  input logic        mosi_level,
  input logic        chip_select_n,
  input logic        busy_res,
  input logic        frame_done,
  input logic [31:0] read_word,
  input logic        start_rejected
);

  // No result may be left over from before a reset.
  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result present right after reset");

  a_cs_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (chip_select_n != busy_res))
    else $error("chip select disagrees with busy");

  // An idle bus has SCK and MOSI low.
  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (!empty && !busy_res) |-> (!sck_level && !mosi_level))
    else $error("pins not idle outside a frame");

  a_word_only_on_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_done) |-> (read_word == 32'd0))
    else $error("received word shown without frame end");

  a_reject_while_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && start_rejected) |-> (busy_res && !frame_done))
    else $error("start rejected while no frame was running");

endmodule

bind spi_register_frame_master_unit srfm_checker u_srfm_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .sck_level      (sck_level),
  .mosi_level     (mosi_level),
  .chip_select_n  (chip_select_n),
  .busy_res       (busy_res),
  .frame_done     (frame_done),
  .read_word      (read_word),
  .start_rejected (start_rejected)
);
